### design/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants for the matrix to quaternion block
// Case codes, the classified item, queue status and width helpers.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int QW            = 16;  // result field width
	localparam int DW            = 18;  // width of a sum or difference of two entries
	localparam int QDEPTH        = 4;   // front to back queue depth
	localparam int DIV_STEPS     = QW;  // one quotient bit per divider stage

	localparam logic signed [QW-1:0] QMAX = 16'sh7fff;
	localparam logic signed [QW-1:0] QMIN = 16'sh8000;

	// which branch the front picked
	typedef enum logic [1:0] {
		SEL_TRACE,
		SEL_AX0,
		SEL_AX1,
		SEL_AX2
	} sel_t;

	// classified item: branch and the three numerators for the divider
	typedef struct packed {
		sel_t                 sel;
		logic signed [DW-1:0] d0;
		logic signed [DW-1:0] d1;
		logic signed [DW-1:0] d2;
	} cls_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_st_t;

	// radicand width (unsigned, nonnegative after clamp)
	function automatic int a_width(int f);
		return ((f > 17) ? f : 17) + 1;
	endfunction

	// root width: half of the radicand width after the fraction shift
	function automatic int r_width(int f);
		return (a_width(f) + f + 1) >> 1;
	endfunction

endpackage

### design/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front: accept and classify
// Picks the trace or axis branch, forms the radicand and three numerators.
// ----------------------------------------------------------------------------
module rmq_front #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [15:0]                      m00,
	input  logic signed [15:0]                      m01,
	input  logic signed [15:0]                      m02,
	input  logic signed [15:0]                      m10,
	input  logic signed [15:0]                      m11,
	input  logic signed [15:0]                      m12,
	input  logic signed [15:0]                      m20,
	input  logic signed [15:0]                      m21,
	input  logic signed [15:0]                      m22,
	input  logic                                    fifo_full,
	output logic                                    push,
	output rmq_pkg::cls_t                           cls_s1,
	output logic [rmq_pkg::a_width(FRAC_BITS)-1:0]  rad_s1
);
	import rmq_pkg::*;

	localparam int A_W = a_width(FRAC_BITS);
	localparam int S_W = A_W + 1;

	logic                  v_s1;
	logic signed [S_W-1:0] e00, e11, e22, one, trace, rad_c;
	logic signed [DW-1:0]  f01, f02, f10, f12, f20, f21;
	logic signed [15:0]    mii;
	logic                  ax1, ax2;
	cls_t                  cls_c;

	// sign extension of the entries
	assign e00 = S_W'(m00);
	assign e11 = S_W'(m11);
	assign e22 = S_W'(m22);
	assign one = S_W'(1) <<< FRAC_BITS;
	assign f01 = DW'(m01);
	assign f02 = DW'(m02);
	assign f10 = DW'(m10);
	assign f12 = DW'(m12);
	assign f20 = DW'(m20);
	assign f21 = DW'(m21);

	// branch pick: strict compares, lower axis wins ties
	assign trace = e00 + e11 + e22;
	assign ax1   = m11 > m00;
	assign mii   = ax1 ? m11 : m00;
	assign ax2   = m22 > mii;

	always_comb begin
		priority if (trace > 0) cls_c.sel = SEL_TRACE;
		else if (ax2)           cls_c.sel = SEL_AX2;
		else if (ax1)           cls_c.sel = SEL_AX1;
		else                    cls_c.sel = SEL_AX0;

		unique case (cls_c.sel)
			SEL_TRACE: begin
				rad_c    = trace + one;
				cls_c.d0 = f21 - f12;
				cls_c.d1 = f02 - f20;
				cls_c.d2 = f10 - f01;
			end
			SEL_AX0: begin
				rad_c    = e00 - e11 - e22 + one;
				cls_c.d0 = f21 - f12;
				cls_c.d1 = f10 + f01;
				cls_c.d2 = f20 + f02;
			end
			SEL_AX1: begin
				rad_c    = e11 - e22 - e00 + one;
				cls_c.d0 = f02 - f20;
				cls_c.d1 = f21 + f12;
				cls_c.d2 = f01 + f10;
			end
			default: begin
				rad_c    = e22 - e00 - e11 + one;
				cls_c.d0 = f10 - f01;
				cls_c.d1 = f02 + f20;
				cls_c.d2 = f12 + f21;
			end
		endcase
	end

	// handshake: hold the stage while the queue is full
	assign push     = v_s1 && !fifo_full;
	assign in_stall = v_s1 && fifo_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	// stage register, negative radicand clamped to zero
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cls_s1 <= cls_c;
			rad_s1 <= (rad_c > 0) ? rad_c[A_W-1:0] : '0;
		end
	end

endmodule

### design/rmq_fifo.sv
// ----------------------------------------------------------------------------
// rmq_fifo: short queue between front and back
// Flop storage, power of two depth, head shown combinationally.
// ----------------------------------------------------------------------------
module rmq_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = rmq_pkg::QDEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [WIDTH-1:0]   wdata,
	input  logic               pop,
	output logic [WIDTH-1:0]   rdata,
	output rmq_pkg::fifo_st_t  status
);
	import rmq_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0]      wr_q, rd_q;

	assign status.empty = (wr_q == rd_q);
	assign status.full  = (wr_q[AW] != rd_q[AW]) && (wr_q[AW-1:0] == rd_q[AW-1:0]);
	assign rdata        = mem_q[rd_q[AW-1:0]];

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push && !status.full) wr_q <= wr_q + 1'b1;
			if (pop && !status.empty) rd_q <= rd_q + 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push && !status.full) mem_q[wr_q[AW-1:0]] <= wdata;
	end

endmodule

### design/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt: pipelined integer square root
// floor(sqrt(rad << FRAC_BITS)), one root bit per stage, tag rides along.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
	parameter int TAG_W     = 1
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic [rmq_pkg::a_width(FRAC_BITS)-1:0] rad,
	input  logic [TAG_W-1:0]                       tag_in,
	output logic                                   out_valid,
	output logic [rmq_pkg::r_width(FRAC_BITS)-1:0] root,
	output logic [TAG_W-1:0]                       tag_out
);
	import rmq_pkg::*;

	localparam int R_W  = r_width(FRAC_BITS);
	localparam int V_W  = 2 * R_W;
	localparam int RM_W = R_W + 3;

	logic [RM_W-1:0]  rem_q  [R_W];
	logic [R_W-1:0]   root_q [R_W];
	logic [V_W-1:0]   vr_q   [R_W];
	logic [TAG_W-1:0] tag_q  [R_W];
	logic [R_W-1:0]   vld_q;

	for (genvar k = 0; k < R_W; k++) begin : g_stage
		logic [RM_W-1:0]  rem_p, rem_sh, trial, rem_n;
		logic [R_W-1:0]   root_p;
		logic [V_W-1:0]   vr_p;
		logic [TAG_W-1:0] tag_p;
		logic             vld_p, ge;

		if (k == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign vr_p   = V_W'(rad) << FRAC_BITS;
			assign tag_p  = tag_in;
			assign vld_p  = in_valid;
		end else begin : g_next
			assign rem_p  = rem_q[k-1];
			assign root_p = root_q[k-1];
			assign vr_p   = vr_q[k-1];
			assign tag_p  = tag_q[k-1];
			assign vld_p  = vld_q[k-1];
		end

		// bring down two bits, try root*4+1
		assign rem_sh = {rem_p[RM_W-3:0], vr_p[V_W-1 -: 2]};
		assign trial  = RM_W'({root_p, 2'b01});
		assign ge     = rem_sh >= trial;
		assign rem_n  = ge ? (rem_sh - trial) : rem_sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= rem_n;
				root_q[k] <= {root_p[R_W-2:0], ge};
				vr_q[k]   <= vr_p << 2;
				tag_q[k]  <= tag_p;
			end
		end
	end

	assign out_valid = vld_q[R_W-1];
	assign root      = root_q[R_W-1];
	assign tag_out   = tag_q[R_W-1];

endmodule

### design/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div: three-lane pipelined scaling divider
// round(d * ONE / (2s)) with ties away from zero, saturated to 16 bits.
// ----------------------------------------------------------------------------
module rmq_div #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
	parameter int TAG_W     = 1
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic signed [rmq_pkg::DW-1:0]          d0,
	input  logic signed [rmq_pkg::DW-1:0]          d1,
	input  logic signed [rmq_pkg::DW-1:0]          d2,
	input  logic [rmq_pkg::r_width(FRAC_BITS)-1:0] s,
	input  logic [TAG_W-1:0]                       tag_in,
	output logic                                   out_valid,
	output logic signed [rmq_pkg::QW-1:0]          q0,
	output logic signed [rmq_pkg::QW-1:0]          q1,
	output logic signed [rmq_pkg::QW-1:0]          q2,
	output logic [TAG_W-1:0]                       tag_out
);
	import rmq_pkg::*;

	localparam int R_W = r_width(FRAC_BITS);
	localparam int C_W = ((DW + FRAC_BITS > R_W + QW) ? DW + FRAC_BITS : R_W + QW) + 1;
	localparam int NS  = DIV_STEPS;

	logic [C_W-1:0]       rem_q [3][NS];
	logic [QW-1:0]        quo_q [3][NS];
	logic                 neg_q [3][NS];
	logic [R_W:0]         den_q [NS];
	logic [TAG_W-1:0]     tag_q [NS];
	logic [NS-1:0]        vld_q;
	logic signed [DW-1:0] din   [3];
	logic signed [QW-1:0] qout  [3];

	assign din[0] = d0;
	assign din[1] = d1;
	assign din[2] = d2;

	for (genvar t = 0; t < NS; t++) begin : g_stage
		logic [R_W:0]     den_p;
		logic [TAG_W-1:0] tag_p;
		logic             vld_p;
		logic [C_W-1:0]   dsh;

		if (t == 0) begin : g_first
			assign den_p = {s, 1'b0};
			assign tag_p = tag_in;
			assign vld_p = in_valid;
		end else begin : g_next
			assign den_p = den_q[t-1];
			assign tag_p = tag_q[t-1];
			assign vld_p = vld_q[t-1];
		end

		// divisor aligned to this quotient bit
		assign dsh = C_W'(den_p) << (NS - 1 - t);

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [C_W-1:0] rem_p, rem_n;
			logic [QW-1:0]  quo_p;
			logic           neg_p, ge;

			if (t == 0) begin : g_prep
				logic [DW-1:0] mag;
				// magnitude, shifted, plus s for rounding
				assign neg_p = din[l] < 0;
				assign mag   = neg_p ? DW'(-din[l]) : DW'(din[l]);
				assign rem_p = (C_W'(mag) << FRAC_BITS) + C_W'(s);
				assign quo_p = '0;
			end else begin : g_chain
				assign neg_p = neg_q[l][t-1];
				assign rem_p = rem_q[l][t-1];
				assign quo_p = quo_q[l][t-1];
			end

			assign ge    = rem_p >= dsh;
			assign rem_n = ge ? (rem_p - dsh) : rem_p;

			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[l][t] <= rem_n;
					quo_q[l][t] <= {quo_p[QW-2:0], ge};
					neg_q[l][t] <= neg_p;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[t] <= 1'b0;
			end else if (en) begin
				vld_q[t] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_q[t] <= den_p;
				tag_q[t] <= tag_p;
			end
		end
	end

	// top quotient bit set means the magnitude reached 32768: saturate
	for (genvar l = 0; l < 3; l++) begin : g_out
		logic [QW-1:0] qf;
		logic          nf;
		assign qf = quo_q[l][NS-1];
		assign nf = neg_q[l][NS-1];
		always_comb begin
			priority if (qf[QW-1]) qout[l] = nf ? QMIN : QMAX;
			else if (nf)           qout[l] = -$signed(qf);
			else                   qout[l] = $signed(qf);
		end
	end

	assign q0        = qout[0];
	assign q1        = qout[1];
	assign q2        = qout[2];
	assign out_valid = vld_q[NS-1];
	assign tag_out   = tag_q[NS-1];

endmodule

### design/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: 3x3 rotation matrix to unit quaternion
// Front classifies (trace or axis branch), queue, back runs sqrt and divides.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled, no dependence between items.
// Path from the accepting edge to out_valid: queue, one sqrt stage per root bit,
// 16 divider stages, output register.
// The back pipeline advances only while the output register can move.
// Reset (arst_n low, asynchronous) empties the pipeline and the queue.
module rotation_matrix_to_quaternion #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [15:0]            m00,
	input  logic signed [15:0]            m01,
	input  logic signed [15:0]            m02,
	input  logic signed [15:0]            m10,
	input  logic signed [15:0]            m11,
	input  logic signed [15:0]            m12,
	input  logic signed [15:0]            m20,
	input  logic signed [15:0]            m21,
	input  logic signed [15:0]            m22,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [rmq_pkg::QW-1:0] quat_w,
	output logic signed [rmq_pkg::QW-1:0] quat_x,
	output logic signed [rmq_pkg::QW-1:0] quat_y,
	output logic signed [rmq_pkg::QW-1:0] quat_z
);
	import rmq_pkg::*;

	localparam int A_W   = a_width(FRAC_BITS);
	localparam int R_W   = r_width(FRAC_BITS);
	localparam int CLS_W = $bits(cls_t);
	localparam int ITM_W = CLS_W + A_W;
	localparam int DT_W  = $bits(sel_t) + QW + 1;

	cls_t                 cls_s1, cls_sq;
	logic [A_W-1:0]       rad_s1, rad_hd;
	logic                 push, pop, en;
	fifo_st_t             q_st;
	logic [ITM_W-1:0]     head;
	logic                 sq_valid, dv_valid;
	logic [R_W-1:0]       root;
	logic [CLS_W-1:0]     sq_tag;
	logic [R_W:0]         half_w;
	logic signed [QW-1:0] half_c, half_d;
	logic                 zero_c, zero_d;
	sel_t                 sel_d;
	logic signed [QW-1:0] r0, r1, r2;
	logic                 out_valid_q;
	logic [DT_W-1:0]      dv_tag;
	cls_t                 head_cls;

	// front: classify
	rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.m00(m00), .m01(m01), .m02(m02),
		.m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22),
		.fifo_full(q_st.full),
		.push     (push),
		.cls_s1   (cls_s1),
		.rad_s1   (rad_s1)
	);

	// queue between front and back
	rmq_fifo #(.WIDTH(ITM_W), .DEPTH(QDEPTH)) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata ({cls_s1, rad_s1}),
		.pop   (pop),
		.rdata (head),
		.status(q_st)
	);

	// back advances whenever the output register is free or being taken
	assign en       = !out_valid_q || !out_stall;
	assign pop      = en && !q_st.empty;
	assign head_cls = cls_t'(head[ITM_W-1 -: CLS_W]);
	assign rad_hd   = head[A_W-1:0];

	rmq_sqrt #(.FRAC_BITS(FRAC_BITS), .TAG_W(CLS_W)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (pop),
		.rad      (rad_hd),
		.tag_in   (head_cls),
		.out_valid(sq_valid),
		.root     (root),
		.tag_out  (sq_tag)
	);

	// half component, s/2 rounded half up and saturated
	assign cls_sq = cls_t'(sq_tag);
	assign half_w = ({1'b0, root} + (R_W+1)'(1)) >> 1;
	assign half_c = (32'(half_w) > 32'(QMAX)) ? QMAX : QW'(half_w);
	assign zero_c = (root == '0);

	rmq_div #(.FRAC_BITS(FRAC_BITS), .TAG_W(DT_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_valid),
		.d0       (cls_sq.d0),
		.d1       (cls_sq.d1),
		.d2       (cls_sq.d2),
		.s        (root),
		.tag_in   ({cls_sq.sel, half_c, zero_c}),
		.out_valid(dv_valid),
		.q0       (r0),
		.q1       (r1),
		.q2       (r2),
		.tag_out  (dv_tag)
	);

	assign sel_d  = sel_t'(dv_tag[DT_W-1 -: $bits(sel_t)]);
	assign half_d = dv_tag[QW:1];
	assign zero_d = dv_tag[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	// output register: place the half component, zero the rest on a zero root
	always_ff @(posedge clk) begin
		if (en) begin
			unique case (sel_d)
				SEL_TRACE: begin
					quat_w <= half_d;
					quat_x <= zero_d ? '0 : r0;
					quat_y <= zero_d ? '0 : r1;
					quat_z <= zero_d ? '0 : r2;
				end
				SEL_AX0: begin
					quat_w <= zero_d ? '0 : r0;
					quat_x <= half_d;
					quat_y <= zero_d ? '0 : r1;
					quat_z <= zero_d ? '0 : r2;
				end
				SEL_AX1: begin
					quat_w <= zero_d ? '0 : r0;
					quat_x <= zero_d ? '0 : r2;
					quat_y <= half_d;
					quat_z <= zero_d ? '0 : r1;
				end
				default: begin
					quat_w <= zero_d ? '0 : r0;
					quat_x <= zero_d ? '0 : r1;
					quat_y <= zero_d ? '0 : r2;
					quat_z <= half_d;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	// queue can never be full and empty at once
	a_q_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_st.full && q_st.empty))
		else $error("queue full and empty together");

	// a push that is not matched by a pop leaves the queue nonempty
	a_q_fill: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> !q_st.empty)
		else $error("queue lost an item");

	// a stalled result holds the back pipeline, so the result is still there
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !en)
		else $error("back pipeline moved under a stalled result");

endmodule

### verif/tb_rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion: self-checking bench for the matrix to
// quaternion converter
// Drives rotation and arbitrary matrices with bursty valid and random output
// stall, predicts each quaternion in integer fixed point and compares fields.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion;

	localparam int FB  = rmq_pkg::FRAC_BITS_DEF;
	localparam int ONE = 1 << FB;
	localparam int LAT = 40;

	typedef logic signed [15:0] ent_t;
	typedef struct packed {
		ent_t w;
		ent_t x;
		ent_t y;
		ent_t z;
	} quat_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	ent_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic out_valid;
	logic out_stall;
	ent_t quat_w, quat_x, quat_y, quat_z;

	quat_t quat_expected[$];
	int err_count;
	int sent_count;
	int got_count;
	int trace_count;
	int axis_count;
	int zero_root_count;
	bit stall_free;

	rotation_matrix_to_quaternion dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.m00(m00), .m01(m01), .m02(m02),
		.m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22),
		.out_valid(out_valid), .out_stall(out_stall),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("timeout after %0d items sent, %0d checked", sent_count, got_count);
		$display("tb_rotation_matrix_to_quaternion: errors");
		$finish;
	end

	// integer square root, bit by bit
	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned root_of(longint a);
		if (a <= 0) return 0;
		return int_sqrt(longint'(a) << FB);
	endfunction

	// d * ONE / (2s), nearest, ties away from zero
	function automatic longint scaled(longint d, longint unsigned s);
		longint unsigned mag;
		longint unsigned q;
		mag = (d < 0) ? longint'(-d) : d;
		q = ((mag << FB) + s) / (s * 2);
		if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
		return (d < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic ent_t clip16(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return ent_t'(v);
	endfunction

	// expected quaternion for one matrix
	function automatic quat_t matrix_to_quat(ent_t e[9]);
		longint m[3][3];
		longint q[3];
		longint w;
		longint tr;
		longint unsigned s;
		int i, j, k;
		quat_t res;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				m[r][c] = e[r*3+c];
		tr = m[0][0] + m[1][1] + m[2][2];
		if (tr > 0) begin
			trace_count++;
			s = root_of(tr + ONE);
			w = (s + 1) >> 1;
			q[0] = scaled(m[2][1] - m[1][2], s);
			q[1] = scaled(m[0][2] - m[2][0], s);
			q[2] = scaled(m[1][0] - m[0][1], s);
		end else begin
			axis_count++;
			i = 0;
			if (m[1][1] > m[0][0]) i = 1;
			if (m[2][2] > m[i][i]) i = 2;
			j = (i + 1) % 3;
			k = (j + 1) % 3;
			s = root_of(m[i][i] - (m[j][j] + m[k][k]) + ONE);
			q[i] = (s + 1) >> 1;
			if (s != 0) begin
				w = scaled(m[k][j] - m[j][k], s);
				q[j] = scaled(m[j][i] + m[i][j], s);
				q[k] = scaled(m[k][i] + m[i][k], s);
			end else begin
				zero_root_count++;
				w = 0;
				q[j] = 0;
				q[k] = 0;
			end
		end
		res.w = clip16(w);
		res.x = clip16(q[0]);
		res.y = clip16(q[1]);
		res.z = clip16(q[2]);
		return res;
	endfunction

	task automatic report_mismatch(string what, ent_t got, ent_t want);
		$display("mismatch %s at result %0d: got %0d expected %0d",
			what, got_count, got, want);
		err_count++;
	endtask

	// send one matrix; random gap first, burst-like via gap probability
	task automatic send_matrix(ent_t e[9]);
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		m00 <= e[0]; m01 <= e[1]; m02 <= e[2];
		m10 <= e[3]; m11 <= e[4]; m12 <= e[5];
		m20 <= e[6]; m21 <= e[7]; m22 <= e[8];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		quat_expected.push_back(matrix_to_quat(e));
		sent_count++;
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		quat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (quat_expected.size() == 0) begin
				$display("result with nothing expected");
				err_count++;
			end else begin
				want = quat_expected.pop_front();
				if (quat_w !== want.w) report_mismatch("w", quat_w, want.w);
				if (quat_x !== want.x) report_mismatch("x", quat_x, want.x);
				if (quat_y !== want.y) report_mismatch("y", quat_y, want.y);
				if (quat_z !== want.z) report_mismatch("z", quat_z, want.z);
			end
			got_count++;
		end
	end

	// receiver stall pattern: stretches free of stall, otherwise random
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0) stall_free <= ~stall_free;
		if (stall_free) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(0, 2) == 0);
	end

	function automatic ent_t rnd16();
		return ent_t'($urandom_range(0, 65535));
	endfunction

	task automatic test_directed();
		ent_t e[9];
		// identity and its negation
		e = '{16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, 16'sd16384};
		send_matrix(e);
		e = '{-16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, -16'sd16384};
		send_matrix(e);
		// half turns about each axis
		e = '{16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, -16'sd16384};
		send_matrix(e);
		e = '{-16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, -16'sd16384};
		send_matrix(e);
		e = '{-16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, 16'sd16384};
		send_matrix(e);
		// trace exactly zero
		e = '{16'sd100, 16'sd5, -16'sd7, 16'sd3, -16'sd100, 16'sd9, 16'sd1, 16'sd2, 0};
		send_matrix(e);
		// diagonal ties: all equal, pairs equal
		e = '{-16'sd500, 16'sd10, 16'sd20, 16'sd30, -16'sd500, 16'sd40, 16'sd50, 16'sd60,
			-16'sd500};
		send_matrix(e);
		e = '{0, 1, 2, 3, 0, 4, 5, 6, -16'sd8};
		send_matrix(e);
		e = '{-16'sd8, 1, 2, 3, 0, 4, 5, 6, 0};
		send_matrix(e);
		// axis branch with a wide diagonal spread, and with all diagonal entries at minimum
		e = '{-16'sd20000, 16'sd100, 0, 0, -16'sd30000, 0, 0, 0, 16'sd30000};
		send_matrix(e);
		e = '{-16'sd32768, 0, 0, 0, -16'sd32768, 0, 0, 0, -16'sd32768};
		send_matrix(e);
		// all extremes
		e = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
			16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};
		send_matrix(e);
		e = '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
			-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767};
		send_matrix(e);
		// tiny trace with big off-diagonals saturates the vector part; then big off-diagonals in the axis branch
		e = '{1, -16'sd32768, 16'sd32767, 16'sd32767, 0, -16'sd32768, -16'sd32768,
			16'sd32767, 0};
		send_matrix(e);
		e = '{-16'sd16384, 16'sd32767, -16'sd32768, -16'sd32768, -16'sd16383,
			16'sd32767, 16'sd32767, -16'sd32768, -16'sd16384};
		send_matrix(e);
		go_idle();
	endtask

	// random matrices: fully random, entries in +-16384, or small noise with a chosen diagonal
	task automatic test_random(int count);
		ent_t e[9];
		int mode;
		for (int n = 0; n < count; n++) begin
			mode = $urandom_range(0, 9);
			for (int t = 0; t < 9; t++) begin
				if (mode < 3) e[t] = rnd16();
				else if (mode < 5) e[t] = ent_t'($signed($urandom_range(0, 32768)) - 16384);
				else e[t] = ent_t'($signed($urandom_range(0, 400)) - 200);
			end
			if (mode >= 5) begin
				// force a chosen diagonal shape
				e[0] = ent_t'($signed($urandom_range(0, 32768)) - 16384);
				e[4] = (mode == 6) ? e[0] : ent_t'($signed($urandom_range(0, 32768)) - 16384);
				e[8] = (mode == 7) ? ent_t'(-e[0] - e[4]) :
					ent_t'($signed($urandom_range(0, 32768)) - 16384);
			end
			send_matrix(e);
			if ($urandom_range(0, 40) == 0) go_idle();
		end
		go_idle();
	endtask

	// hold off until the pipeline has drained completely
	task automatic drain_wait();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (quat_expected.size() != 0 && guard < 200_000) begin
			@(posedge clk);
			guard++;
		end
		repeat (LAT) @(posedge clk);
	endtask

	initial begin
		err_count = 0;
		sent_count = 0;
		got_count = 0;
		trace_count = 0;
		axis_count = 0;
		zero_root_count = 0;
		stall_free = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		{m00, m01, m02, m10, m11, m12, m20, m21, m22} = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		drain_wait();
		test_random(950);
		drain_wait();
		test_random(1000);
		drain_wait();
		$display("sent %0d matrices: %0d trace branch, %0d axis branch (%0d zero root)",
			sent_count, trace_count, axis_count, zero_root_count);
		if (err_count == 0 && quat_expected.size() == 0) begin
			$display("tb_rotation_matrix_to_quaternion: clean");
		end else begin
			$display("%0d mismatches, %0d results still expected", err_count,
				quat_expected.size());
			$display("tb_rotation_matrix_to_quaternion: errors");
		end
		$finish;
	end

endmodule

### files.f
design/rmq_pkg.sv
design/rmq_front.sv
design/rmq_fifo.sv
design/rmq_sqrt.sv
design/rmq_div.sv
design/rotation_matrix_to_quaternion.sv
verif/tb_rotation_matrix_to_quaternion.sv
